/* hw/rtl/ert_pkg.sv */
// shared types and constants of the exclusive reservation table
`default_nettype none

package ert_pkg;

    // payload widths
    localparam int MODE_W = 2;
    localparam int CPU_W  = 4;
    localparam int ADDR_W = 32;
    localparam int WORD_W = 30;
    localparam int CFG_W  = 5;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 5;

    // reset value of the processor count register
    localparam logic [CFG_W-1:0] CPU_COUNT_RST = CFG_W'(3);

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_MARK  = 2'd0,
        MODE_TEST  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    // status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_MISSING   = 2'd1,
        STAT_OVER_CPUS = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    // per-cell control from the sequencer
    typedef struct packed {
        logic occupied;
        logic ld_new;
        logic ld_next;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hw/rtl/ert_in_if.sv */
// request channel: operation, processor and byte address
`default_nettype none

interface ert_in_if;
    logic                        valid;
    logic                        ready;
    logic [ert_pkg::MODE_W-1:0]  mode;
    logic [ert_pkg::CPU_W-1:0]   cpu_id;
    logic [ert_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output mode, output cpu_id, output address, input ready);
    modport sink   (input valid, input mode, input cpu_id, input address, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ert_out_if.sv */
// response channel: test result, status and entry count
`default_nettype none

interface ert_out_if;
    logic                        valid;
    logic                        ready;
    logic                        test_fail;
    logic [ert_pkg::STAT_W-1:0]  status;
    logic [ert_pkg::ECNT_W-1:0]  entry_count;

    modport source (output valid, output test_fail, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input test_fail, input status, input entry_count,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/ert_cfg_if.sv */
// configuration write channel for the processor count
`default_nettype none

interface ert_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ert_pkg::CFG_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ert_cell.sv */
// one table cell: holds a reservation, compares it, takes its right neighbor on a shift
`default_nettype none

module ert_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ert_pkg::t_cell_ctl          i_ctl,
    input  wire logic [ert_pkg::WORD_W-1:0]  i_word,
    input  wire logic [ert_pkg::CPU_W-1:0]   i_cpu,
    input  wire logic [ert_pkg::WORD_W-1:0]  i_next_word,
    input  wire logic [ert_pkg::CPU_W-1:0]   i_next_cpu,
    output logic      [ert_pkg::WORD_W-1:0]  o_word,
    output logic      [ert_pkg::CPU_W-1:0]   o_cpu,
    output logic                             o_hit
);
    import ert_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [CPU_W-1:0]  r_cpu;
    logic              r_hit;

    // entry storage: new reservation or shift from the right neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_new) begin
            r_word <= i_word;
            r_cpu  <= i_cpu;
        end else if (i_ctl.ld_next) begin
            r_word <= i_next_word;
            r_cpu  <= i_next_cpu;
        end
    end

    // registered match against the broadcast word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= i_ctl.occupied && (r_word == i_word);
        end
    end

    assign o_word = r_word;
    assign o_cpu  = r_cpu;
    assign o_hit  = r_hit;

endmodule

`default_nettype wire

/* hw/rtl/ert_enc.sv */
// folds the row of match flags into position, presence and owner
`default_nettype none

module ert_enc #(
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [DEPTH-1:0]           i_hit,
    input  wire logic [ert_pkg::CPU_W-1:0]  i_cpu [DEPTH],
    output logic      [$clog2(DEPTH)-1:0]   o_pos,
    output logic                            o_present,
    output logic      [ert_pkg::CPU_W-1:0]  o_owner
);
    import ert_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic [IW-1:0]    n_pos;
    logic [CPU_W-1:0] n_owner;
    logic [IW-1:0]    r_pos;
    logic             r_present;
    logic [CPU_W-1:0] r_owner;

    // at most one cell matches, so a plain or of masked values encodes it
    always_comb begin
        n_pos   = '0;
        n_owner = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i_hit[i]) begin
                n_pos   = n_pos | IW'(i);
                n_owner = n_owner | i_cpu[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_owner <= n_owner;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
        end else begin
            r_present <= |i_hit;
        end
    end

    assign o_pos     = r_pos;
    assign o_present = r_present;
    assign o_owner   = r_owner;

endmodule

`default_nettype wire

/* hw/rtl/exclusive_reservation_table.sv */
// top level: sequencer, entry count and row of reservation cells
//
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   mode, cpu_id, address
//  o_out    out  valid/ready   test_fail, status, entry_count
//  i_cfg    in   valid/ready   data (cpu_count)
//
// one request at a time: accept, compare in every cell, encode the match,
// update the row; the response is registered in the update state, after the cell match
// and encoder registers. the next request is taken the cycle after the response is loaded,
// so the block takes no new request while one is in its compare, encode or update step.
// reset empties the table (count zero) and sets cpu_count to 3; cell contents need no
// reset. a stalled response holds the update step until the response register frees up.
`default_nettype none

module exclusive_reservation_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ert_in_if.sink      i_in,
    ert_out_if.source   o_out,
    ert_cfg_if.sink     i_cfg
);
    import ert_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ENC,
        S_UPD
    } t_state;

    t_state r_state;

    // latched request
    logic [MODE_W-1:0] r_mode;
    logic [CPU_W-1:0]  r_cpu;
    logic [WORD_W-1:0] r_word;

    logic [CW-1:0]     r_count;
    logic [CFG_W-1:0]  r_cpu_count;

    logic              r_out_valid;
    logic              r_test_fail;
    t_status           r_status;
    logic [CW-1:0]     r_out_count;

    // row wiring
    t_cell_ctl         cell_ctl  [TABLE_DEPTH];
    logic [WORD_W-1:0] cell_word [TABLE_DEPTH];
    logic [CPU_W-1:0]  cell_cpu  [TABLE_DEPTH];
    logic [WORD_W-1:0] next_word [TABLE_DEPTH];
    logic [CPU_W-1:0]  next_cpu  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_hit;

    logic [IW-1:0]     enc_pos;
    logic              enc_present;
    logic [CPU_W-1:0]  enc_owner;

    logic              in_beat;
    logic              upd_fire;
    logic              do_add;
    logic              do_del;
    logic [CW-1:0]     n_count;
    logic              n_test_fail;
    t_status           n_status;

    assign in_beat  = i_in.valid && i_in.ready;
    assign upd_fire = (r_state == S_UPD) && (!r_out_valid || o_out.ready);

    assign do_add = (r_mode == MODE_MARK) && !enc_present
                    && (r_count < CW'(TABLE_DEPTH));
    assign do_del = (r_mode == MODE_CLEAR) && enc_present;

    // result of the operation
    always_comb begin
        n_count     = r_count;
        n_test_fail = 1'b0;
        n_status    = STAT_OK;
        if (r_mode == MODE_MARK) begin
            if (!enc_present) begin
                if (r_count >= CW'(TABLE_DEPTH)) begin
                    n_status = STAT_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    if (KW'(n_count) > KW'(r_cpu_count)) begin
                        n_status = STAT_OVER_CPUS;
                    end
                end
            end
        end else if (r_mode == MODE_TEST) begin
            n_test_fail = !(enc_present && (enc_owner == r_cpu));
        end else if (r_mode == MODE_CLEAR) begin
            if (enc_present) begin
                n_count = r_count - CW'(1);
            end else begin
                n_status = STAT_MISSING;
            end
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_mode <= i_in.mode;
            r_cpu  <= i_in.cpu_id;
            r_word <= i_in.address[ADDR_W-1:2];
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_test_fail <= n_test_fail;
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    // sequencer, entry count, response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_ENC;
                end
                S_ENC: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_fire) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // processor count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_count <= CPU_COUNT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_cpu_count <= i_cfg.data;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    assign o_out.valid       = r_out_valid;
    assign o_out.test_fail   = r_test_fail;
    assign o_out.status      = r_status;
    assign o_out.entry_count = ECNT_W'(r_out_count);

    // row of cells, each but the last fed by its right neighbor
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign next_word[g] = cell_word[g];
            assign next_cpu[g]  = cell_cpu[g];
        end else begin : g_mid
            assign next_word[g] = cell_word[g+1];
            assign next_cpu[g]  = cell_cpu[g+1];
        end

        assign cell_ctl[g].occupied = (CW'(g) < r_count);
        assign cell_ctl[g].ld_new   = upd_fire && do_add && (r_count == CW'(g));
        assign cell_ctl[g].ld_next  = upd_fire && do_del && (IW'(g) >= enc_pos)
                                      && (g < TABLE_DEPTH - 1);

        ert_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl[g]),
            .i_word      (r_word),
            .i_cpu       (r_cpu),
            .i_next_word (next_word[g]),
            .i_next_cpu  (next_cpu[g]),
            .o_word      (cell_word[g]),
            .o_cpu       (cell_cpu[g]),
            .o_hit       (cell_hit[g])
        );
    end

    // match encoder
    ert_enc #(
        .DEPTH (TABLE_DEPTH)
    ) u_enc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hit     (cell_hit),
        .i_cpu     (cell_cpu),
        .o_pos     (enc_pos),
        .o_present (enc_present),
        .o_owner   (enc_owner)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// self-checking bench for the exclusive reservation table: directed cases and random traffic against a predictor
module tb_top;
    import ert_pkg::*;

    localparam int DEPTH         = 16;
    localparam int POOL_SIZE     = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int MAX_PRINTED   = 50;

    // unused operation code, the block answers it without touching the table
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CPU_W-1:0]  cpu;
        logic [ADDR_W-1:0] addr;
    } t_req;

    typedef struct packed {
        logic              test_fail;
        logic [STAT_W-1:0] status;
        logic [ECNT_W-1:0] entry_count;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    ert_in_if  in_ch ();
    ert_out_if out_ch ();
    ert_cfg_if cfg_ch ();

    exclusive_reservation_table #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted table contents, compacted below held_count
    logic [WORD_W-1:0] held_word [DEPTH];
    logic [CPU_W-1:0]  held_cpu  [DEPTH];
    int                held_count = 0;
    logic [CFG_W-1:0]  cpu_limit  = CPU_COUNT_RST;

    t_req              pending_reqs [$];
    t_reply            replies_due  [$];
    logic [ADDR_W-1:0] addr_pool    [POOL_SIZE];

    int err_count      = 0;
    int idle_cycles    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit in_fire        = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one request to the predicted table and return the reply it gives
    function automatic t_reply reservation_outcome(t_req r);
        logic [WORD_W-1:0] w;
        int                pos;
        bit                hit;
        t_reply            res;
        w   = r.addr[ADDR_W-1:2];
        pos = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
            if (held_word[i] == w) pos = i;
        end
        hit           = pos < held_count;
        res.test_fail = 1'b0;
        res.status    = STAT_OK;
        case (r.mode)
            MODE_MARK: begin
                if (!hit) begin
                    if (held_count >= DEPTH) begin
                        res.status = STAT_FULL;
                    end else begin
                        held_word[held_count] = w;
                        held_cpu[held_count]  = r.cpu;
                        held_count++;
                        if (held_count > int'(cpu_limit)) res.status = STAT_OVER_CPUS;
                    end
                end
            end
            MODE_TEST: begin
                res.test_fail = !(hit && held_cpu[pos] == r.cpu);
            end
            MODE_CLEAR: begin
                if (hit) begin
                    // close the gap left by the removed entry
                    for (int i = pos; i + 1 < held_count; i++) begin
                        held_word[i] = held_word[i+1];
                        held_cpu[i]  = held_cpu[i+1];
                    end
                    held_count--;
                end else begin
                    res.status = STAT_MISSING;
                end
            end
            default: ;
        endcase
        res.entry_count = ECNT_W'(held_count);
        return res;
    endfunction

    task automatic flag_error(string msg);
        if (err_count < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic push_req(logic [MODE_W-1:0] mode, logic [CPU_W-1:0] cpu,
                            logic [ADDR_W-1:0] addr);
        t_req r;
        r.mode = mode;
        r.cpu  = cpu;
        r.addr = addr;
        pending_reqs.push_back(r);
    endtask

    // wait until every request is answered, then let the block settle
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_ch.valid || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // request driver and reply back-pressure
    always @(negedge i_clk) begin
        t_req nr;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            if (!in_ch.valid || in_fire) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nr = pending_reqs.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.mode    <= nr.mode;
                    in_ch.cpu_id  <= nr.cpu;
                    in_ch.address <= nr.addr;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor: predict on request beats, check reply beats, watchdog
    always @(posedge i_clk) begin
        t_reply want;
        t_req   got_req;
        if (i_rst_n) begin
            in_fire = in_ch.valid && in_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready) cpu_limit = cfg_ch.data;
            if (in_fire) begin
                got_req.mode = in_ch.mode;
                got_req.cpu  = in_ch.cpu_id;
                got_req.addr = in_ch.address;
                replies_due.push_back(reservation_outcome(got_req));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (replies_due.size() == 0) begin
                    flag_error("reply beat with no request outstanding");
                end else begin
                    want = replies_due.pop_front();
                    if (out_ch.test_fail !== want.test_fail)
                        flag_error($sformatf("test_fail %b, predicted %b",
                                             out_ch.test_fail, want.test_fail));
                    if (out_ch.status !== want.status)
                        flag_error($sformatf("status %0d, predicted %0d",
                                             out_ch.status, want.status));
                    if (out_ch.entry_count !== want.entry_count)
                        flag_error($sformatf("entry_count %0d, predicted %0d",
                                             out_ch.entry_count, want.entry_count));
                end
            end
            if (in_fire || (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // stimulus: reset, directed cases, then random phases
    initial begin
        t_req             r;
        int               pick;
        int               mark_pct;
        int               clear_pct;
        logic [CFG_W-1:0] cfg_val;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_MARK;
        in_ch.cpu_id  = '0;
        in_ch.address = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = CPU_COUNT_RST;
        i_rst_n       = 1'b0;

        // directed cases with the reset processor count of three
        push_req(MODE_TEST,  4'd0,  32'h0000_0000);  // test on an empty table
        push_req(MODE_CLEAR, 4'd0,  32'h0000_0000);  // clear of a missing word
        push_req(MODE_MARK,  4'd0,  32'h0000_0000);
        push_req(MODE_MARK,  4'd5,  32'h0000_0003);  // same word, other cpu: no change
        push_req(MODE_TEST,  4'd0,  32'h0000_0002);  // owner passes
        push_req(MODE_TEST,  4'd5,  32'h0000_0000);  // other cpu fails
        push_req(MODE_MARK,  4'd15, 32'hFFFF_FFFF);
        push_req(MODE_MARK,  4'd1,  32'h0000_0004);
        push_req(MODE_MARK,  4'd2,  32'h0000_0008);  // fourth entry exceeds cpu count
        push_req(MODE_TEST,  4'd15, 32'hFFFF_FFFC);
        push_req(MODE_SPARE, 4'd15, 32'hFFFF_FFFF);  // unused mode is ignored
        push_req(MODE_CLEAR, 4'd9,  32'h0000_0001);  // clear by a non-owner, head entry
        push_req(MODE_TEST,  4'd1,  32'h0000_0004);  // entry moved down after clear
        push_req(MODE_CLEAR, 4'd0,  32'hFFFF_FFFE);
        push_req(MODE_CLEAR, 4'd0,  32'hFFFF_FFFE);  // now missing
        push_req(MODE_TEST,  4'd2,  32'h0000_0009);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom();

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();

            // processor count write while the block is idle
            case (ph)
                0:       cfg_val = 5'd1;
                1:       cfg_val = 5'd16;
                2:       cfg_val = 5'd0;
                3:       cfg_val = 5'd31;
                default: cfg_val = CFG_W'($urandom_range(31));
            endcase
            @(negedge i_clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= cfg_val;
            do @(posedge i_clk); while (!cfg_ch.ready);
            @(negedge i_clk);
            cfg_ch.valid <= 1'b0;
            @(posedge i_clk);

            // idle pattern of this phase
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin src_idle_pct = 12; sink_stall_pct = 12; end
            endcase

            // fill-heavy, drain-heavy and mixed operation mixes
            case (ph % 3)
                0: begin mark_pct = 70; clear_pct = 10; end
                1: begin mark_pct = 30; clear_pct = 55; end
                default: begin mark_pct = 45; clear_pct = 30; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 2)
                    r.mode = MODE_SPARE;
                else if (pick < 2 + mark_pct)
                    r.mode = MODE_MARK;
                else if (pick < 2 + mark_pct + clear_pct)
                    r.mode = MODE_CLEAR;
                else
                    r.mode = MODE_TEST;
                // few cpus most of the time so that owner tests pass often
                r.cpu = ($urandom_range(9) < 7) ? CPU_W'($urandom_range(3))
                                                : CPU_W'($urandom_range(15));
                // mostly pooled words with random byte offsets, some wild addresses
                if ($urandom_range(9) == 0)
                    r.addr = $urandom();
                else
                    r.addr = {addr_pool[$urandom_range(POOL_SIZE-1)][ADDR_W-1:2],
                              2'($urandom_range(3))};
                pending_reqs.push_back(r);
            end
        end

        wait_drained();
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ert_pkg.sv
hw/rtl/ert_in_if.sv
hw/rtl/ert_out_if.sv
hw/rtl/ert_cfg_if.sv
hw/rtl/ert_cell.sv
hw/rtl/ert_enc.sv
hw/rtl/exclusive_reservation_table.sv
tb/sv/tb_top.sv
